/* rtl/qvr_pkg.sv */
package qvr_pkg;

    // field widths
    localparam int QW = 16;                 // quaternion component, q2.14
    localparam int VW = 32;                 // vector component, q16.16

    // rotation matrix coefficient, scale 2^-28, fits in 34 bits signed
    localparam int CW = 34;
    // coefficient split into a signed high part and an unsigned low part
    localparam int LO_BITS = 16;
    localparam int MHW = CW - LO_BITS;      // 18
    localparam int MLW = LO_BITS + 1;       // 17, zero-extended low part
    localparam int HPW = MHW + VW;          // 50
    localparam int LPW = MLW + VW;          // 49
    localparam int HSW = HPW + 2;           // three-term sum
    localparam int LSW = LPW + 2;
    localparam int SW = HSW + LO_BITS;      // exact row sum, scale 2^-44
    localparam int RND_SHIFT = 28;          // 2^-44 to 2^-16
    localparam int RW = SW - RND_SHIFT;     // rounded value before clipping

    localparam logic signed [SW-1:0] RND_BIAS = SW'(64'd1) <<< (RND_SHIFT - 1);
    localparam logic signed [VW-1:0] FIX_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] FIX_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef logic signed [QW-1:0] quat_t;
    typedef logic signed [VW-1:0] fix_t;
    typedef logic signed [2*QW-1:0] prod_t;
    typedef logic signed [CW-1:0] mcoef_t;

    // load enables for the stages inside one row unit
    typedef struct packed {
        logic prod;
        logic sum;
        logic rnd;
        logic out;
    } row_ld_t;

endpackage

/* rtl/qvr_row.sv */
module qvr_row (
    input  logic              clk,
    input  qvr_pkg::row_ld_t  ld,
    input  qvr_pkg::mcoef_t   coef [0:2],
    input  qvr_pkg::fix_t     vec  [0:2],
    output qvr_pkg::fix_t     rot,
    output logic              sat
);

    logic signed [qvr_pkg::MHW-1:0] mh [0:2];
    logic signed [qvr_pkg::MLW-1:0] ml [0:2];
    logic signed [qvr_pkg::HPW-1:0] hp_next [0:2];
    logic signed [qvr_pkg::LPW-1:0] lp_next [0:2];
    logic signed [qvr_pkg::HPW-1:0] hp_reg [0:2];
    logic signed [qvr_pkg::LPW-1:0] lp_reg [0:2];
    logic signed [qvr_pkg::HSW-1:0] hsum_next, hsum_reg;
    logic signed [qvr_pkg::LSW-1:0] lsum_next, lsum_reg;
    logic signed [qvr_pkg::SW-1:0]  s_next, s_reg;
    logic signed [qvr_pkg::RW-1:0]  r;
    logic                           ovf;
    qvr_pkg::fix_t                  rot_next, rot_reg;
    logic                           sat_reg;

    // partial products: coefficient split keeps each multiplier at 18x32 or narrower
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            mh[n] = coef[n][qvr_pkg::CW-1:qvr_pkg::LO_BITS];
            ml[n] = {1'b0, coef[n][qvr_pkg::LO_BITS-1:0]};
            hp_next[n] = mh[n] * vec[n];
            lp_next[n] = ml[n] * vec[n];
        end
    end

    assign hsum_next = qvr_pkg::HSW'(hp_reg[0]) + qvr_pkg::HSW'(hp_reg[1])
                     + qvr_pkg::HSW'(hp_reg[2]);
    assign lsum_next = qvr_pkg::LSW'(lp_reg[0]) + qvr_pkg::LSW'(lp_reg[1])
                     + qvr_pkg::LSW'(lp_reg[2]);

    // exact sum plus half an lsb of the result
    assign s_next = (qvr_pkg::SW'(hsum_reg) <<< qvr_pkg::LO_BITS)
                  + qvr_pkg::SW'(lsum_reg) + qvr_pkg::RND_BIAS;

    // floor shift, then clip to 32 bits
    assign r   = s_reg[qvr_pkg::SW-1:qvr_pkg::RND_SHIFT];
    assign ovf = !((&r[qvr_pkg::RW-1:qvr_pkg::VW-1]) || !(|r[qvr_pkg::RW-1:qvr_pkg::VW-1]));

    always_comb
    begin
        if (ovf)
        begin
            rot_next = r[qvr_pkg::RW-1] ? qvr_pkg::FIX_MIN : qvr_pkg::FIX_MAX;
        end
        else
        begin
            rot_next = r[qvr_pkg::VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.prod)
        begin
            hp_reg <= hp_next;
            lp_reg <= lp_next;
        end
        if (ld.sum)
        begin
            hsum_reg <= hsum_next;
            lsum_reg <= lsum_next;
        end
        if (ld.rnd)
        begin
            s_reg <= s_next;
        end
        if (ld.out)
        begin
            rot_reg <= rot_next;
            sat_reg <= ovf;
        end
    end

    assign rot = rot_reg;
    assign sat = sat_reg;

endmodule

/* rtl/quaternion_vector_rotate.sv */
// quaternion vector rotation: each item carries q = (w,i,j,k) in signed q2.14
// and v = (x,y,z) in signed q16.16; the result is the vector part of
// q*(0,v)*conj(q), evaluated as the rotation matrix of q times v, rounded once
// to q16.16 (half toward plus infinity) and clipped to 32 bits, with tuser
// flagging any clipped component. q is not normalized, so the result scales
// by |q|^2; a zero quaternion gives the zero vector. the block is a six-stage
// pipeline (quaternion products, matrix coefficients, coefficient-by-vector
// partial products, row sums, rounding add, clip and output register), and a new
// item can be taken every cycle while the input is not stalled. each stage holds its
// item under backpressure and bubbles are squeezed out, so s_axis_tready drops
// only when all six stages are full and m_axis_tready is low. there is no state
// between items and nothing to configure.
module quaternion_vector_rotate (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // quat_w[15:0], quat_i[31:16], quat_j[47:32], quat_k[63:48],
    // vec_x[95:64], vec_y[127:96], vec_z[159:128]
    input  logic [159:0] s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x[31:0], rot_y[63:32], rot_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // saturated[0]
    output logic [0:0]   m_axis_tuser
);

    localparam int NSTG = 6;

    // stage valid bits and per-stage ready (stage k may load)
    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG:0]   rdy;

    // input unpacking
    qvr_pkg::quat_t qw, qi, qj, qk;
    qvr_pkg::fix_t  vin [0:2];

    // stage 0: the ten distinct quaternion products
    qvr_pkg::prod_t ww_reg, ii_reg, jj_reg, kk_reg;
    qvr_pkg::prod_t ij_reg, ik_reg, jk_reg, wi_reg, wj_reg, wk_reg;
    qvr_pkg::fix_t  v0_reg [0:2];

    // stage 1: rotation matrix, [row][col]
    qvr_pkg::mcoef_t coef_next [0:2][0:2];
    qvr_pkg::mcoef_t coef_reg  [0:2][0:2];
    qvr_pkg::fix_t   v1_reg [0:2];

    qvr_pkg::row_ld_t row_ld;
    qvr_pkg::fix_t    rot [0:2];
    logic [2:0]       row_sat;

    assign qw     = s_axis_tdata[15:0];
    assign qi     = s_axis_tdata[31:16];
    assign qj     = s_axis_tdata[47:32];
    assign qk     = s_axis_tdata[63:48];
    assign vin[0] = s_axis_tdata[95:64];
    assign vin[1] = s_axis_tdata[127:96];
    assign vin[2] = s_axis_tdata[159:128];

    // a stage loads when empty or when the stage after it moves on
    always_comb
    begin
        rdy[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 0 payload: 16x16 products
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ww_reg <= qw * qw;
            ii_reg <= qi * qi;
            jj_reg <= qj * qj;
            kk_reg <= qk * qk;
            ij_reg <= qi * qj;
            ik_reg <= qi * qk;
            jk_reg <= qj * qk;
            wi_reg <= qw * qi;
            wj_reg <= qw * qj;
            wk_reg <= qw * qk;
            v0_reg <= vin;
        end
    end

    // stage 1: matrix coefficients, off-diagonal terms doubled
    always_comb
    begin
        coef_next[0][0] = qvr_pkg::CW'(ww_reg) + qvr_pkg::CW'(ii_reg)
                        - qvr_pkg::CW'(jj_reg) - qvr_pkg::CW'(kk_reg);
        coef_next[0][1] = (qvr_pkg::CW'(ij_reg) - qvr_pkg::CW'(wk_reg)) <<< 1;
        coef_next[0][2] = (qvr_pkg::CW'(ik_reg) + qvr_pkg::CW'(wj_reg)) <<< 1;
        coef_next[1][0] = (qvr_pkg::CW'(ij_reg) + qvr_pkg::CW'(wk_reg)) <<< 1;
        coef_next[1][1] = qvr_pkg::CW'(ww_reg) - qvr_pkg::CW'(ii_reg)
                        + qvr_pkg::CW'(jj_reg) - qvr_pkg::CW'(kk_reg);
        coef_next[1][2] = (qvr_pkg::CW'(jk_reg) - qvr_pkg::CW'(wi_reg)) <<< 1;
        coef_next[2][0] = (qvr_pkg::CW'(ik_reg) - qvr_pkg::CW'(wj_reg)) <<< 1;
        coef_next[2][1] = (qvr_pkg::CW'(jk_reg) + qvr_pkg::CW'(wi_reg)) <<< 1;
        coef_next[2][2] = qvr_pkg::CW'(ww_reg) - qvr_pkg::CW'(ii_reg)
                        - qvr_pkg::CW'(jj_reg) + qvr_pkg::CW'(kk_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            coef_reg <= coef_next;
            v1_reg   <= v0_reg;
        end
    end

    // stages 2..5 live in the row units
    assign row_ld.prod = rdy[2];
    assign row_ld.sum  = rdy[3];
    assign row_ld.rnd  = rdy[4];
    assign row_ld.out  = rdy[5];

    generate
        for (genvar g = 0; g < 3; g++)
        begin : g_row
            qvr_row u_row (
                .clk  (clk),
                .ld   (row_ld),
                .coef (coef_reg[g]),
                .vec  (v1_reg),
                .rot  (rot[g]),
                .sat  (row_sat[g])
            );
        end
    endgenerate

    assign s_axis_tready   = rdy[0];
    assign m_axis_tvalid   = valid_reg[NSTG-1];
    assign m_axis_tdata    = {rot[2], rot[1], rot[0]};
    assign m_axis_tuser[0] = |row_sat;

    // a flagged item has at least one component pinned at a rail
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (rot[0] == qvr_pkg::FIX_MAX) || (rot[0] == qvr_pkg::FIX_MIN) ||
            (rot[1] == qvr_pkg::FIX_MAX) || (rot[1] == qvr_pkg::FIX_MIN) ||
            (rot[2] == qvr_pkg::FIX_MAX) || (rot[2] == qvr_pkg::FIX_MIN))
        else $error("saturated flag without a clipped component");

    // input side stalls only when the whole pipe is full and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&valid_reg) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // items in flight change only by accepted inputs and delivered outputs
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) ==
            $past($countones(valid_reg))
            + ($past(s_axis_tvalid && s_axis_tready) ? 1 : 0)
            - ($past(m_axis_tvalid && m_axis_tready) ? 1 : 0))
        else $error("item lost or duplicated in the pipeline");

endmodule

/* tb/sv/quaternion_vector_rotate_test.sv */
module quaternion_vector_rotate_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef qvr_pkg::quat_t quat_t;
    typedef qvr_pkg::fix_t  fix_t;

    localparam fix_t FIX_MAX = qvr_pkg::FIX_MAX;
    localparam fix_t FIX_MIN = qvr_pkg::FIX_MIN;

    // one input item as it travels on s_axis_tdata
    typedef struct packed {
        quat_t w;
        quat_t i;
        quat_t j;
        quat_t k;
        fix_t  x;
        fix_t  y;
        fix_t  z;
    } rot_in_t;

    // one result item, tdata fields plus the clip flag from tuser
    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
        logic sat;
    } rot_out_t;

    // directed row: typed rows carry their own answer, the rest use the predictor
    typedef struct packed {
        rot_in_t  din;
        logic     typed;
        rot_out_t dout;
    } stim_row_t;

    // q2.14 shorthands
    localparam quat_t Q_ONE  = 16'sd16384;
    localparam quat_t Q_HALF = 16'sd8192;
    localparam quat_t Q_MIN  = 16'sh8000;
    localparam quat_t Q_MAX  = 16'sh7fff;
    localparam fix_t  V_ONE  = 32'sd65536;

    localparam rot_out_t NO_RESULT = '0;

    localparam int DIR_ROWS   = 19;
    localparam int RAND_ITEMS = 530;
    localparam int BLOCK_LEN  = 50;
    localparam int IDLE_LIMIT = 1000;   // far above the long hold and any gap pair
    localparam int LONG_HOLD  = 150;

    localparam logic signed [127:0] LIM_HI  = 128'sd2147483647;
    localparam logic signed [127:0] LIM_LO  = -128'sd2147483648;
    localparam logic signed [127:0] RND_ADD = 128'sh8000000;     // half an lsb at 2^-44

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;     // quat_w, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;     // rot_x, rot_y, rot_z
    logic [0:0]   m_axis_tuser;     // saturated

    quaternion_vector_rotate uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // rotations still in flight, oldest first
    rot_out_t rotations_pending[$];

    int n_sent;
    int n_checked;
    int n_clipped;
    int n_errors;
    int n_in_stalls;
    int idle_cycles;

    // idling modes: 0 = gaps of 0..17, 1 = back to back, 2 = mostly back to back
    int snd_mode;
    int rcv_mode;
    int hold_len;

    // directed table: identity, zero, rounding ties, clipping, axis flips, bit patterns
    stim_row_t stim_tab [DIR_ROWS] = '{
        // identity passes the vector through unchanged
        '{'{Q_ONE, 16'sd0, 16'sd0, 16'sd0, V_ONE, -V_ONE, 32'sd123}, 1'b1,
          '{V_ONE, -V_ONE, 32'sd123, 1'b0}},
        '{'{Q_ONE, 16'sd0, 16'sd0, 16'sd0, FIX_MAX, FIX_MIN, 32'sd0}, 1'b1,
          '{FIX_MAX, FIX_MIN, 32'sd0, 1'b0}},
        // zero quaternion gives the zero vector
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, FIX_MAX, FIX_MIN, 32'sd12345}, 1'b1,
          '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
        // quarter scale: ties round toward plus infinity
        '{'{Q_HALF, 16'sd0, 16'sd0, 16'sd0, 32'sd2, -32'sd2, -32'sd3}, 1'b1,
          '{32'sd1, 32'sd0, -32'sd1, 1'b0}},
        '{'{Q_HALF, 16'sd0, 16'sd0, 16'sd0, 32'sd6, -32'sd6, 32'sd1}, 1'b1,
          '{32'sd2, -32'sd1, 32'sd0, 1'b0}},
        // w = -2.0 scales by four, hitting both ends of the range
        '{'{Q_MIN, 16'sd0, 16'sd0, 16'sd0, 32'sh1fffffff, -32'sh20000000, 32'sh20000000},
          1'b1, '{32'sh7ffffffc, FIX_MIN, FIX_MAX, 1'b1}},
        // half turns about each axis; negating the minimum clips
        '{'{16'sd0, Q_ONE, 16'sd0, 16'sd0, 32'sd0, FIX_MIN, 32'sd5}, 1'b1,
          '{32'sd0, FIX_MAX, -32'sd5, 1'b1}},
        '{'{16'sd0, 16'sd0, Q_ONE, 16'sd0, 32'sd7, -32'sd9, FIX_MAX}, 1'b1,
          '{-32'sd7, -32'sd9, 32'sh80000001, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, Q_ONE, FIX_MIN, 32'sd100, -32'sd100}, 1'b1,
          '{FIX_MAX, -32'sd100, -32'sd100, 1'b1}},
        '{'{16'sd0, Q_MIN, 16'sd0, 16'sd0, -32'sd1, 32'sd1, 32'sh20000000}, 1'b1,
          '{-32'sd4, -32'sd4, FIX_MIN, 1'b0}},
        // all components at the minimum: gain 16 on permuted axes, clips everywhere
        '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, FIX_MAX, FIX_MAX, FIX_MAX}, 1'b1,
          '{FIX_MAX, FIX_MAX, FIX_MAX, 1'b1}},
        '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, FIX_MIN, FIX_MIN, FIX_MIN}, 1'b1,
          '{FIX_MIN, FIX_MIN, FIX_MIN, 1'b1}},
        // predictor rows
        '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_ONE, V_ONE, V_ONE}, 1'b0, NO_RESULT},
        '{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, V_ONE, 32'sd0, 32'sd0}, 1'b0,
          NO_RESULT},
        '{'{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 32'sd1, -32'sd1, FIX_MAX}, 1'b0, NO_RESULT},
        '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
            32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f}, 1'b0, NO_RESULT},
        '{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
            32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0}, 1'b0, NO_RESULT},
        '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, FIX_MIN, FIX_MAX, -32'sd1}, 1'b0,
          NO_RESULT},
        '{'{Q_ONE, Q_ONE, Q_ONE, Q_ONE, V_ONE, 2 * V_ONE, 3 * V_ONE}, 1'b0, NO_RESULT}
    };

    // q * (0,v) * conj(q) in matrix form, exact sum at 2^-44, one rounding, clip
    function automatic rot_out_t rotate_expect(input rot_in_t a);
        logic signed [127:0] w, i, j, k, ww, ii, jj, kk, acc, r;
        logic signed [127:0] mtx [9];
        logic signed [127:0] vin [3];
        fix_t                comp [3];
        logic                sat;
        rot_out_t            res;
        w = $signed(a.w);
        i = $signed(a.i);
        j = $signed(a.j);
        k = $signed(a.k);
        vin[0] = $signed(a.x);
        vin[1] = $signed(a.y);
        vin[2] = $signed(a.z);
        ww = w * w;
        ii = i * i;
        jj = j * j;
        kk = k * k;
        mtx[0] = ww + ii - jj - kk;
        mtx[1] = 2 * (i * j - w * k);
        mtx[2] = 2 * (i * k + w * j);
        mtx[3] = 2 * (i * j + w * k);
        mtx[4] = ww - ii + jj - kk;
        mtx[5] = 2 * (j * k - w * i);
        mtx[6] = 2 * (i * k - w * j);
        mtx[7] = 2 * (j * k + w * i);
        mtx[8] = ww - ii - jj + kk;
        sat = 1'b0;
        for (int rr = 0; rr < 3; rr++)
        begin
            acc = mtx[3*rr] * vin[0] + mtx[3*rr+1] * vin[1] + mtx[3*rr+2] * vin[2];
            r = (acc + RND_ADD) >>> 28;     // floor keeps ties going up
            if (r > LIM_HI)
            begin
                comp[rr] = FIX_MAX;
                sat = 1'b1;
            end
            else if (r < LIM_LO)
            begin
                comp[rr] = FIX_MIN;
                sat = 1'b1;
            end
            else
            begin
                comp[rr] = r[31:0];
            end
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.sat = sat;
        return res;
    endfunction

    function automatic int gap_for(input int mode);
        case (mode)
            1:       return 0;
            2:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic quat_t quat_edge();
        case ($urandom_range(0, 5))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return 16'sd0;
            3:       return -16'sd1;
            4:       return 16'sd1;
            default: return ($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE;
        endcase
    endfunction

    function automatic fix_t vec_edge();
        case ($urandom_range(0, 5))
            0:       return FIX_MAX;
            1:       return FIX_MIN;
            2:       return 32'sd0;
            3:       return 32'sd1;
            4:       return -32'sd1;
            default: return ($urandom_range(0, 1) != 0) ? V_ONE : -V_ONE;
        endcase
    endfunction

    // random quaternion shapes: raw bits, near unit, single axis, corner values
    function automatic quat_t quat_draw(input int shape, input bit on_axis);
        case (shape)
            0:       return quat_t'($urandom);
            1:       return quat_t'(int'($urandom_range(0, 32768)) - 16384);
            2:       return on_axis ? quat_edge() : 16'sd0;
            default: return quat_edge();
        endcase
    endfunction

    function automatic fix_t vec_draw(input int shape);
        case (shape)
            0:       return fix_t'($urandom);
            1:       return fix_t'(int'($urandom_range(0, 32'h200000)) - 32'h100000);
            default: return vec_edge();
        endcase
    endfunction

    function automatic rot_in_t rot_in_draw();
        rot_in_t it;
        int      qs;
        int      vs;
        int      ax;
        qs = $urandom_range(0, 3);
        vs = $urandom_range(0, 2);
        ax = $urandom_range(0, 3);
        it.w = quat_draw(qs, ax == 0);
        it.i = quat_draw(qs, ax == 1);
        it.j = quat_draw(qs, ax == 2);
        it.k = quat_draw(qs, ax == 3);
        it.x = vec_draw(vs);
        it.y = vec_draw(vs);
        it.z = vec_draw(vs);
        return it;
    endfunction

    // offer one item from a falling edge, wait for the handshake, end on a falling edge
    task automatic offer_item(input rot_in_t it, input logic typed, input rot_out_t want);
        int g;
        g = gap_for(snd_mode);
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.z, it.y, it.x, it.k, it.j, it.i, it.w};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        rotations_pending.push_back(typed ? want : rotate_expect(it));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        n_errors++;
        if (n_errors <= 10)
            $display("result %0d field %s: expected %h, got %h", n_checked, fname, want, got);
    endtask

    // clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on handshake progress, plus input stall count
    always @(posedge clk)
    begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (s_axis_tvalid === 1'b1 && s_axis_tready !== 1'b1)
            n_in_stalls++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, rotations_pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random ready gaps, one long hold on request, field compare
    initial
    begin
        rot_out_t want;
        rot_out_t got;
        int       g;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                g = hold_len;
                hold_len = 0;
            end
            else
            begin
                g = gap_for(rcv_mode);
            end
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            got.x   = m_axis_tdata[31:0];
            got.y   = m_axis_tdata[63:32];
            got.z   = m_axis_tdata[95:64];
            got.sat = m_axis_tuser[0];
            if (rotations_pending.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result with nothing outstanding: %h", m_axis_tdata);
            end
            else
            begin
                want = rotations_pending.pop_front();
                if (got.x !== want.x)
                    report_field("rot_x", want.x, got.x);
                if (got.y !== want.y)
                    report_field("rot_y", want.y, got.y);
                if (got.z !== want.z)
                    report_field("rot_z", want.z, got.z);
                if (got.sat !== want.sat)
                    report_field("saturated", 32'(want.sat), 32'(got.sat));
                if (want.sat)
                    n_clipped++;
                n_checked++;
            end
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        int remaining;
        int run;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        snd_mode      = 0;
        rcv_mode      = 0;
        hold_len      = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_clipped     = 0;
        n_errors      = 0;
        n_in_stalls   = 0;
        idle_cycles   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            offer_item(stim_tab[r].din, stim_tab[r].typed, stim_tab[r].dout);

        // sender waits for the pipeline to drain completely
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (rotations_pending.size() != 0);

        // receiver holds off while the sender streams back to back: input must stall
        snd_mode = 1;
        rcv_mode = 1;
        hold_len = LONG_HOLD;
        for (int n = 0; n < 40; n++)
            offer_item(rot_in_draw(), 1'b0, NO_RESULT);

        // random blocks, each with its own idling mix on both sides
        remaining = RAND_ITEMS - 40;
        while (remaining > 0)
        begin
            snd_mode = $urandom_range(0, 2);
            rcv_mode = $urandom_range(0, 2);
            run = (remaining < BLOCK_LEN) ? remaining : BLOCK_LEN;
            for (int n = 0; n < run; n++)
                offer_item(rot_in_draw(), 1'b0, NO_RESULT);
            remaining -= run;
        end

        // drain, then idle on to catch anything stray behind the six-stage pipeline
        s_axis_tvalid <= 1'b0;
        while (rotations_pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("rotated %0d items (%0d directed), checked %0d results, %0d clipped",
                 n_sent, DIR_ROWS, n_checked, n_clipped);
        $display("input back-pressured for %0d cycles, %0d mismatches",
                 n_in_stalls, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
